// ----- sv/bss_pkg.sv -----
// shared constants and types for the byte substring search block
package bss_pkg;

  // window depth and pattern capacity, one cell per byte
  localparam int unsigned MaxPattern = 64;

  localparam int unsigned DataW = 8;
  localparam int unsigned LenW  = 7;
  localparam int unsigned PidxW = 6;
  localparam int unsigned OffW  = 32;

  // replay counter width, at least one bit
  localparam int unsigned CntW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  // per-cycle commands broadcast along the cell chain
  typedef struct packed {
    logic step;   // shift window, advance partial matches
    logic clear;  // end of search, drop window and partial matches
    logic load;   // pattern load, partial matches become stale
  } cell_ctl_t;

  // one search result
  typedef struct packed {
    logic            found;
    logic [OffW-1:0] offset;
  } res_t;

endpackage

// ----- sv/bss_cell.sv -----
// one cell of the search chain: pattern byte, window byte, partial match bit
module bss_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bss_pkg::cell_ctl_t       ctl_i,
  input  logic                     pat_we_i,
  input  logic [bss_pkg::DataW-1:0] feed_byte_i,
  input  logic [bss_pkg::DataW-1:0] win_prev_i,
  input  logic                     match_prev_i,
  output logic [bss_pkg::DataW-1:0] win_o,
  output logic                     match_o,
  output logic                     match_d_o
);

  logic [bss_pkg::DataW-1:0] pat_q;
  logic [bss_pkg::DataW-1:0] win_q, win_d;
  logic                      match_q, match_d;
  logic                      hit;

  // bytes ending at the newest one equal pattern bytes 0..this cell
  assign hit = (feed_byte_i == pat_q) && match_prev_i;

  always_comb begin
    win_d   = win_q;
    match_d = match_q;
    priority if (ctl_i.clear) begin
      win_d   = '0;
      match_d = 1'b0;
    end else if (ctl_i.step) begin
      win_d   = win_prev_i;
      match_d = hit;
    end else if (ctl_i.load) begin
      match_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      match_q <= 1'b0;
    end else begin
      win_q   <= win_d;
      match_q <= match_d;
    end
  end

  // pattern store entry, undefined until written
  always_ff @(posedge clk_i) begin
    if (pat_we_i) begin
      pat_q <= feed_byte_i;
    end
  end

  assign win_o     = win_q;
  assign match_o   = match_q;
  assign match_d_o = hit;

endmodule

// ----- sv/bss_skid.sv -----
// two-entry result buffer so the input side keeps flowing while a result waits
module bss_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bss_pkg::res_t push_data_i,
  input  logic          pop_ready_i,
  output logic          valid_o,
  output bss_pkg::res_t data_o,
  output logic          full_o
);

  bss_pkg::res_t out_q, out_d, skid_q, skid_d;
  logic          out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic          pop;

  assign pop = out_valid_q && pop_ready_i;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    priority if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;
  assign full_o  = skid_valid_q;

endmodule

// ----- sv/byte_substring_search_top.sv -----
// top level of the byte substring search block: cell chain, counters, result buffer
//
//   channel   direction  handshake                payload
//   cfg       in         cfg_valid_i/cfg_ready_o  cfg_data_i (pattern length)
//   in        in         in_valid_i/in_ready_o    mode_i data_byte_i pattern_index_i last_byte_i
//   out       out        out_valid_o/out_ready_i  found_o match_offset_o
//
// one haystack byte or pattern load per cycle unless input stalls; results are buffered
// a pattern load during a search stalls input while the window is
//   rotated once through the cell chain to rebuild the partial match bits
// reset is asynchronous and active low; no clearing pass, the block is ready at once
// a waiting result does not stall input; input stalls while both result slots are full
//   and while a replay runs
module byte_substring_search_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration transaction
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bss_pkg::LenW-1:0]      cfg_data_i,
  // input transaction
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [bss_pkg::DataW-1:0]     data_byte_i,
  input  logic [bss_pkg::PidxW-1:0]     pattern_index_i,
  input  logic                          last_byte_i,
  // result transaction
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [bss_pkg::OffW-1:0]      match_offset_o
);

  localparam int unsigned N = bss_pkg::MaxPattern;

  // pattern length register
  logic [bss_pkg::LenW-1:0] len_q;

  // search state
  logic [bss_pkg::OffW-1:0] bytes_seen_q, bytes_inc;
  logic                     match_seen_q;
  logic [bss_pkg::OffW-1:0] first_offset_q;

  // replay after a mid-search pattern load
  logic                     replay_q;
  logic [bss_pkg::CntW-1:0] rep_cnt_q;

  // handshake decode
  logic in_fire, hay_fire, load_fire, skid_full;

  // cell chain
  bss_pkg::cell_ctl_t        ctl;
  logic [bss_pkg::DataW-1:0] win [N];
  logic [N-1:0]              m_q, m_d, pat_we;
  logic [bss_pkg::DataW-1:0] feed_byte;

  // match evaluation
  logic [bss_pkg::OffW-1:0] len_ext, new_off, cur_off;
  logic                     sel_hit, new_hit, cur_seen;
  bss_pkg::res_t            push_res, out_res;

  // config is always taken; the user must write only while idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_valid_i) begin
      len_q <= cfg_data_i;
    end
  end

  assign in_ready_o = !replay_q && !skid_full;
  assign in_fire    = in_valid_i && in_ready_o;
  assign hay_fire   = in_fire && mode_i;
  assign load_fire  = in_fire && !mode_i;

  // during replay the oldest window byte re-enters at the head of the chain
  assign feed_byte = replay_q ? win[N-1] : data_byte_i;

  assign ctl.step  = hay_fire || replay_q;
  assign ctl.clear = hay_fire && last_byte_i;
  assign ctl.load  = load_fire;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [bss_pkg::DataW-1:0] win_prev;
    logic                      match_prev;

    if (i == 0) begin : g_head
      assign win_prev   = feed_byte;
      assign match_prev = 1'b1;
    end else begin : g_body
      assign win_prev   = win[i-1];
      assign match_prev = m_q[i-1];
    end

    // loads past the store depth hit no cell and are dropped
    assign pat_we[i] = load_fire && (32'(pattern_index_i) == 32'(i));

    bss_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .pat_we_i     (pat_we[i]),
      .feed_byte_i  (feed_byte),
      .win_prev_i   (win_prev),
      .match_prev_i (match_prev),
      .win_o        (win[i]),
      .match_o      (m_q[i]),
      .match_d_o    (m_d[i])
    );
  end

  // saturating haystack byte count
  assign bytes_inc = (bytes_seen_q == '1) ? bytes_seen_q : bytes_seen_q + 1'b1;
  assign len_ext   = {{(bss_pkg::OffW - bss_pkg::LenW){1'b0}}, len_q};

  // pick the partial match bit of the cell at pattern length; zero or too long picks none
  always_comb begin
    sel_hit = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (len_ext == bss_pkg::OffW'(i + 1)) begin
        sel_hit = m_d[i];
      end
    end
  end

  assign new_hit  = !match_seen_q && sel_hit && (bytes_inc >= len_ext);
  assign new_off  = bytes_inc - len_ext;
  assign cur_seen = match_seen_q || new_hit;
  assign cur_off  = match_seen_q ? first_offset_q : new_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q   <= '0;
      match_seen_q   <= 1'b0;
      first_offset_q <= '0;
    end else if (hay_fire) begin
      if (last_byte_i) begin
        bytes_seen_q   <= '0;
        match_seen_q   <= 1'b0;
        first_offset_q <= '0;
      end else begin
        bytes_seen_q <= bytes_inc;
        if (new_hit) begin
          match_seen_q   <= 1'b1;
          first_offset_q <= new_off;
        end
      end
    end
  end

  // a load in the middle of a search rebuilds the partial match bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replay_q  <= 1'b0;
      rep_cnt_q <= '0;
    end else if (load_fire && (bytes_seen_q != '0)) begin
      replay_q  <= 1'b1;
      rep_cnt_q <= '0;
    end else if (replay_q) begin
      rep_cnt_q <= rep_cnt_q + 1'b1;
      if (rep_cnt_q == bss_pkg::CntW'(N - 1)) begin
        replay_q <= 1'b0;
      end
    end
  end

  assign push_res.found  = cur_seen;
  assign push_res.offset = cur_seen ? cur_off : '0;

  bss_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (hay_fire && last_byte_i),
    .push_data_i (push_res),
    .pop_ready_i (out_ready_i),
    .valid_o     (out_valid_o),
    .data_o      (out_res),
    .full_o      (skid_full)
  );

  assign found_o        = out_res.found;
  assign match_offset_o = out_res.offset;

  // replay runs exactly one pass over the window
  a_replay_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    replay_q && (rep_cnt_q == bss_pkg::CntW'(N - 1)) |=> !replay_q)
    else $error("replay did not end after one window pass");

  // a mid-search load blocks input while the chain is rebuilt
  a_replay_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_fire && (bytes_seen_q != '0) |=> replay_q && !in_ready_o)
    else $error("mid-search load did not start replay");

  // a recorded match needs at least one haystack byte
  a_match_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_seen_q |-> (bytes_seen_q != '0))
    else $error("match recorded with empty byte count");

  // not found reports offset zero
  a_nf_offset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (match_offset_o == '0))
    else $error("nonzero offset on not-found result");

endmodule

// ----- test/byte_substring_search_top_test.sv -----
// self-checking testbench for the byte substring search block
`timescale 1ns / 1ps

module byte_substring_search_top_test;

  // mode field codes
  localparam logic ModeLoad   = 1'b0;
  localparam logic ModeSearch = 1'b1;

  localparam int unsigned RandomItems  = 600;
  localparam int unsigned PhaseItems   = 40;
  // covers the result delay plus a full window rotation after a pattern load
  localparam int unsigned SettleCycles = 2 * bss_pkg::MaxPattern + 16;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned MaxReported  = 10;

  // one input transaction as it travels on the in channel
  typedef struct packed {
    logic                      mode;
    logic [bss_pkg::DataW-1:0] data;
    logic [bss_pkg::PidxW-1:0] pidx;
    logic                      last;
  } search_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      cfg_valid = 1'b0;
  logic [bss_pkg::LenW-1:0]  cfg_data = '0;
  logic                      cfg_ready_o;
  logic                      in_valid = 1'b0;
  search_item_t              drv_item = '0;
  logic                      in_ready_o;
  logic                      out_valid_o;
  logic                      out_ready = 1'b0;
  logic                      found_o;
  logic [bss_pkg::OffW-1:0]  match_offset_o;

  // transactions waiting for the driver, results waiting for the monitor
  search_item_t              stim_q[$];
  bss_pkg::res_t             due_q[$];

  // predictor state, updated when the block accepts a transaction
  logic [bss_pkg::DataW-1:0] ref_pattern [bss_pkg::MaxPattern];
  logic [bss_pkg::DataW-1:0] ref_window [bss_pkg::MaxPattern];
  logic [bss_pkg::OffW-1:0]  ref_seen;
  logic                      ref_hit;
  logic [bss_pkg::OffW-1:0]  ref_first;
  logic [bss_pkg::LenW-1:0]  ref_len;

  // generator's view of the pattern store and length, ahead of the block
  logic [bss_pkg::DataW-1:0] gen_pattern [bss_pkg::MaxPattern];
  int unsigned               gen_len;
  int unsigned               queued_items;

  int unsigned               send_idle_pct = 0;
  int unsigned               recv_stall_pct = 0;
  int unsigned               fail_count = 0;
  int unsigned               result_count = 0;
  int unsigned               cycle_count = 0;

  byte_substring_search_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .mode_i          (drv_item.mode),
    .data_byte_i     (drv_item.data),
    .pattern_index_i (drv_item.pidx),
    .last_byte_i     (drv_item.last),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .found_o         (found_o),
    .match_offset_o  (match_offset_o)
  );

  always #10 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // predictor: slide the window, look for the first match, emit on last byte
  // -------------------------------------------------------------------------
  task automatic track_search(input search_item_t it);
    bss_pkg::res_t r;
    logic hit_now;
    int k;
    if (it.mode == ModeLoad) begin
      // last flag is meaningless on a pattern load
      ref_pattern[it.pidx] = it.data;
    end else begin
      for (k = bss_pkg::MaxPattern - 1; k > 0; k--) begin
        ref_window[k] = ref_window[k-1];
      end
      ref_window[0] = it.data;
      // offset counter holds at all ones
      if (ref_seen != '1) begin
        ref_seen = ref_seen + 1'b1;
      end
      // zero length and lengths beyond the window never match,
      // nor does a haystack still shorter than the pattern
      if (!ref_hit && ref_len != 0 && ref_len <= bss_pkg::MaxPattern &&
          ref_seen >= ref_len) begin
        hit_now = 1'b1;
        for (k = 0; k < int'(ref_len); k++) begin
          if (ref_pattern[k] != ref_window[int'(ref_len) - 1 - k]) begin
            hit_now = 1'b0;
          end
        end
        if (hit_now) begin
          ref_hit   = 1'b1;
          ref_first = ref_seen - ref_len;
        end
      end
      if (it.last) begin
        r.found  = ref_hit;
        r.offset = ref_hit ? ref_first : '0;
        due_q = {due_q, r};
        for (k = 0; k < bss_pkg::MaxPattern; k++) begin
          ref_window[k] = '0;
        end
        ref_seen  = '0;
        ref_hit   = 1'b0;
        ref_first = '0;
      end
    end
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReported) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // -------------------------------------------------------------------------
  // driver: present the next pending transaction, predict on acceptance
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        track_search(drv_item);
      end
      // valid only drops or moves on once the current transaction is taken
      if (!in_valid || in_ready_o) begin
        if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          drv_item <= stim_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // monitor: compare each result transaction with the oldest prediction
  // -------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (due_q.size() == 0) begin
          note_failure($sformatf("result %0d with none predicted: found %0b offset %0d",
                                 result_count, found_o, match_offset_o));
        end else begin
          if (found_o !== due_q[0].found) begin
            note_failure($sformatf("result %0d found: expected %0b actual %0b",
                                   result_count, due_q[0].found, found_o));
          end
          if (match_offset_o !== due_q[0].offset) begin
            note_failure($sformatf("result %0d match_offset: expected %0d actual %0d",
                                   result_count, due_q[0].offset, match_offset_o));
          end
          void'(due_q.pop_front());
        end
        result_count++;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------
  task automatic push_item(input logic mode, input logic [bss_pkg::DataW-1:0] data,
                           input logic [bss_pkg::PidxW-1:0] pidx, input logic last);
    search_item_t it;
    it.mode = mode;
    it.data = data;
    it.pidx = pidx;
    it.last = last;
    if (mode == ModeLoad) begin
      gen_pattern[pidx] = data;
    end
    stim_q = {stim_q, it};
    queued_items++;
  endtask

  // haystack byte leaning toward pattern content so partial matches happen
  function automatic logic [bss_pkg::DataW-1:0] pick_byte(input int unsigned span);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) begin
      return gen_pattern[$urandom_range(span - 1)];
    end else if (roll < 80) begin
      return bss_pkg::DataW'($urandom_range(1));
    end
    return bss_pkg::DataW'($urandom);
  endfunction

  // drain both channels, then let the block settle; sampled between edges
  task automatic wait_for_idle;
    while (stim_q.size() != 0 || in_valid || due_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic set_length(input int unsigned len);
    wait_for_idle();
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= bss_pkg::LenW'(len);
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid <= 1'b0;
    ref_len = bss_pkg::LenW'(len);
    gen_len = len;
  endtask

  // one search: random haystack, often with the pattern planted in it,
  // sometimes shorter than the pattern, with rare pattern loads mid-search
  task automatic queue_random_search;
    logic [bss_pkg::DataW-1:0] hay[$];
    int unsigned n;
    int unsigned pos;
    int unsigned k;
    int unsigned span;
    logic fits;
    fits = (gen_len >= 1 && gen_len <= bss_pkg::MaxPattern);
    span = fits ? gen_len : 4;
    if (fits && gen_len > 1 && $urandom_range(9) == 0) begin
      n = $urandom_range(gen_len - 1, 1);
    end else if (fits) begin
      n = $urandom_range(gen_len + 12, gen_len);
    end else begin
      n = $urandom_range(20, 1);
    end
    for (k = 0; k < n; k++) begin
      hay = {hay, pick_byte(span)};
    end
    if (fits && n >= gen_len && $urandom_range(99) < 60) begin
      pos = $urandom_range(n - gen_len);
      for (k = 0; k < gen_len; k++) begin
        hay[pos + k] = gen_pattern[k];
      end
    end
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 3) begin
        push_item(ModeLoad, bss_pkg::DataW'($urandom), bss_pkg::PidxW'($urandom),
                  1'($urandom));
      end
      push_item(ModeSearch, hay[k], bss_pkg::PidxW'($urandom), k == n - 1);
    end
  endtask

  function automatic int unsigned phase_length(input int unsigned phase);
    unique case (phase % 8)
      0: return 1;
      1: return $urandom_range(6, 2);
      2: return bss_pkg::MaxPattern;
      3: return 0;
      4: return $urandom_range(20, 7);
      5: return (1 << bss_pkg::LenW) - 1;
      6: return bss_pkg::MaxPattern + 1;
      default: return $urandom_range(bss_pkg::MaxPattern, 1);
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // test sequence
  // -------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    int unsigned phase_start;
    int unsigned k;
    for (k = 0; k < bss_pkg::MaxPattern; k++) begin
      ref_pattern[k] = '0;
      ref_window[k]  = '0;
      gen_pattern[k] = '0;
    end
    ref_seen     = '0;
    ref_hit      = 1'b0;
    ref_first    = '0;
    ref_len      = '0;
    gen_len      = 0;
    queued_items = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: short pattern with extreme bytes, last flag set on a load
    set_length(3);
    push_item(ModeLoad, 8'h00, 6'd0, 1'b1);
    push_item(ModeLoad, 8'hFF, 6'd1, 1'b0);
    push_item(ModeLoad, 8'hA5, 6'd2, 1'b0);
    push_item(ModeLoad, 8'h5A, 6'd63, 1'b1);
    // match at offset zero
    push_item(ModeSearch, 8'h00, 6'd63, 1'b0);
    push_item(ModeSearch, 8'hFF, 6'd0, 1'b0);
    push_item(ModeSearch, 8'hA5, 6'd0, 1'b1);
    // match at offset zero again, then a match further in
    push_item(ModeSearch, 8'h00, 6'd0, 1'b0);
    push_item(ModeSearch, 8'hFF, 6'd0, 1'b0);
    push_item(ModeSearch, 8'hA5, 6'd0, 1'b1);
    push_item(ModeSearch, 8'h11, 6'd0, 1'b0);
    push_item(ModeSearch, 8'h00, 6'd0, 1'b0);
    push_item(ModeSearch, 8'hFF, 6'd0, 1'b0);
    push_item(ModeSearch, 8'hA5, 6'd0, 1'b0);
    push_item(ModeSearch, 8'h22, 6'd0, 1'b1);
    // haystack shorter than the pattern
    push_item(ModeSearch, 8'h00, 6'd0, 1'b0);
    push_item(ModeSearch, 8'hFF, 6'd0, 1'b1);
    // near miss
    push_item(ModeSearch, 8'h00, 6'd0, 1'b0);
    push_item(ModeSearch, 8'hFF, 6'd0, 1'b0);
    push_item(ModeSearch, 8'h00, 6'd0, 1'b1);
    // length changes in the middle of a search
    push_item(ModeSearch, 8'h77, 6'd0, 1'b0);
    push_item(ModeSearch, 8'h00, 6'd0, 1'b0);
    set_length(2);
    push_item(ModeSearch, 8'hFF, 6'd0, 1'b0);
    push_item(ModeSearch, 8'hA5, 6'd0, 1'b1);
    // zero length never matches
    set_length(0);
    push_item(ModeSearch, 8'h00, 6'd0, 1'b1);
    // pattern load while a search is open
    set_length(3);
    push_item(ModeSearch, 8'h00, 6'd0, 1'b0);
    push_item(ModeSearch, 8'hFF, 6'd0, 1'b0);
    push_item(ModeLoad, 8'h11, 6'd2, 1'b0);
    push_item(ModeSearch, 8'h11, 6'd0, 1'b1);

    // random: fill the whole store so every length reads written entries
    wait_for_idle();
    queued_items = 0;
    for (k = 0; k < bss_pkg::MaxPattern; k++) begin
      push_item(ModeLoad, bss_pkg::DataW'($urandom), bss_pkg::PidxW'(k), 1'($urandom));
    end

    phase = 0;
    while (queued_items < RandomItems) begin
      set_length(phase_length(phase));
      // rotate through idle patterns, first one with none at all
      unique case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      phase_start = queued_items;
      while (queued_items - phase_start < PhaseItems) begin
        // occasional reload of a few pattern entries between searches
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(3, 1)) begin
            push_item(ModeLoad, bss_pkg::DataW'($urandom), bss_pkg::PidxW'($urandom),
                      1'($urandom));
          end
        end
        queue_random_search();
      end
      phase++;
    end

    wait_for_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- byte_substring_search_top.f -----
sv/bss_pkg.sv
sv/bss_cell.sv
sv/bss_skid.sv
sv/byte_substring_search_top.sv
test/byte_substring_search_top_test.sv
